@@ rtl/slst_pkg.sv @@
package slst_pkg;

  // Field widths
  localparam int OP_W   = 3;
  localparam int DUR_W  = 16;
  localparam int TIME_W = 32;
  localparam int MASK_W = 8;
  // Widest span: 65535 * 32 + 5000 stays below 2^22
  localparam int SPAN_W = 22;

  // Opcodes
  localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OP_W-1:0] OP_LEFT   = 3'd1;
  localparam logic [OP_W-1:0] OP_RIGHT  = 3'd2;
  localparam logic [OP_W-1:0] OP_ALL_ON = 3'd3;

  // Status codes
  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_BAD = 1'b1;

  // Timing constants
  localparam int                ALL_ON_EXTRA = 5000;
  localparam logic [TIME_W-1:0] IDLE_START   = '1;

  // Decoded command class
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SCHED = 2'd1,
    CMD_BAD   = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [SPAN_W-1:0] span;
  } cmd_t;

endpackage

@@ rtl/slst_front.sv @@
module slst_front import slst_pkg::*; #(
  parameter int NUM_LIGHTS = 8
) (
  input  logic [OP_W-1:0]  opcode_i,
  input  logic [DUR_W-1:0] duration_ms_i,
  output cmd_t             cmd_o,
  output logic [DUR_W-1:0] delay_o [NUM_LIGHTS]
);

  // Reciprocal for exact floor(x / NUM_LIGHTS), x < 2^XW
  localparam int KW    = (NUM_LIGHTS > 1) ? $clog2(NUM_LIGHTS) : 1;
  localparam int XW    = DUR_W + KW;
  localparam int SHIFT = XW + KW;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(NUM_LIGHTS) - 64'd1) / 64'(NUM_LIGHTS);
  localparam int FW = SHIFT + KW + 1;
  localparam int PW = DUR_W + FW;

  logic is_left;
  logic is_all_on;

  assign is_left   = (opcode_i == OP_LEFT);
  assign is_all_on = (opcode_i == OP_ALL_ON);

  // Classify the opcode and pick the on-time span
  always_comb begin
    cmd_o.span = SPAN_W'(duration_ms_i);
    unique case (opcode_i) inside
      OP_TICK: begin
        cmd_o.kind = CMD_TICK;
      end
      OP_LEFT, OP_RIGHT, OP_ALL_ON: begin
        cmd_o.kind = CMD_SCHED;
        if (is_all_on) begin
          cmd_o.span = SPAN_W'(duration_ms_i) * SPAN_W'(NUM_LIGHTS)
                     + SPAN_W'(ALL_ON_EXTRA);
        end
      end
      default: begin
        cmd_o.kind = CMD_BAD;
      end
    endcase
  end

  // Per-light stagger: floor(T * pos / N) as T * (pos * RECIP) >> SHIFT
  for (genvar k = 0; k < NUM_LIGHTS; k++) begin : g_lane
    localparam longint unsigned FAC_R = 64'(k) * RECIP;
    localparam longint unsigned FAC_L = 64'(NUM_LIGHTS - 1 - k) * RECIP;

    logic [FW-1:0] fac;
    logic [PW-1:0] prod;

    assign fac  = is_left ? FW'(FAC_L) : FW'(FAC_R);
    assign prod = PW'(duration_ms_i) * PW'(fac);
    assign delay_o[k] = is_all_on ? '0 : prod[SHIFT +: DUR_W];
  end

endmodule

@@ rtl/slst_queue.sv @@
module slst_queue import slst_pkg::*; #(
  parameter int NUM_LIGHTS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cmd_t             cmd_i,
  input  logic [DUR_W-1:0] delay_i [NUM_LIGHTS],
  input  logic             pop_i,
  output logic             valid_o,
  output logic             full_o,
  output cmd_t             cmd_o,
  output logic [DUR_W-1:0] delay_o [NUM_LIGHTS]
);

  localparam int DEPTH = 2;

  cmd_t             cmd_q [DEPTH];
  logic [DUR_W-1:0] dly_q [DEPTH][NUM_LIGHTS];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  // Word storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      cmd_q[wr_ptr_q] <= cmd_i;
      dly_q[wr_ptr_q] <= delay_i;
    end
  end

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'(DEPTH));
  assign cmd_o   = cmd_q[rd_ptr_q];
  assign delay_o = dly_q[rd_ptr_q];

endmodule

@@ rtl/slst_back.sv @@
module slst_back import slst_pkg::*; #(
  parameter int NUM_LIGHTS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  cmd_t              cmd_i,
  input  logic [DUR_W-1:0]  delay_i [NUM_LIGHTS],
  output logic              pop_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [MASK_W-1:0] light_mask_o,
  output logic              status_o
);

  logic [TIME_W-1:0]     now_q;
  logic [TIME_W-1:0]     now_inc;
  logic [TIME_W-1:0]     burn_q  [NUM_LIGHTS];
  logic [TIME_W-1:0]     start_q [NUM_LIGHTS];
  logic [NUM_LIGHTS-1:0] lit_q;
  logic [NUM_LIGHTS-1:0] lit_tick;
  logic [NUM_LIGHTS-1:0] lit_d;
  logic [MASK_W-1:0]     mask_d;
  logic                  out_valid_q;
  logic [MASK_W-1:0]     mask_q;
  logic                  status_q;
  logic                  is_tick;
  logic                  is_sched;

  // Take a word when the output register is free or being emptied
  assign pop_o    = valid_i && (!out_valid_q || !out_stall_i);
  assign is_tick  = pop_o && (cmd_i.kind == CMD_TICK);
  assign is_sched = pop_o && (cmd_i.kind == CMD_SCHED);

  // Saturating clock advance
  assign now_inc = (now_q == IDLE_START) ? now_q : now_q + TIME_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q <= '0;
    end else if (is_tick) begin
      now_q <= now_inc;
    end
  end

  // One compare cell per light
  for (genvar k = 0; k < NUM_LIGHTS; k++) begin : g_cell
    logic [TIME_W+1:0] end_sum;
    logic [TIME_W:0]   beg_sum;
    logic [TIME_W-1:0] end_sat;
    logic [TIME_W-1:0] beg_sat;
    logic [TIME_W-1:0] start_tick;

    // Chained saturating sums collapse into one saturated three-input add
    assign end_sum = {2'b00, now_q} + (TIME_W+2)'(cmd_i.span) + (TIME_W+2)'(delay_i[k]);
    assign beg_sum = {1'b0, now_q} + (TIME_W+1)'(delay_i[k]);
    assign end_sat = (end_sum[TIME_W+1:TIME_W] != 2'b00) ? IDLE_START : end_sum[TIME_W-1:0];
    assign beg_sat = beg_sum[TIME_W] ? IDLE_START : beg_sum[TIME_W-1:0];

    // Dark light whose start has passed goes idle
    assign start_tick  = (!lit_q[k] && (now_inc > start_q[k])) ? IDLE_START : start_q[k];
    assign lit_tick[k] = (now_inc < burn_q[k]) && (now_inc >= start_tick);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        burn_q[k]  <= '0;
        start_q[k] <= IDLE_START;
        lit_q[k]   <= 1'b0;
      end else if (is_tick) begin
        start_q[k] <= start_tick;
        lit_q[k]   <= lit_tick[k];
      end else if (is_sched) begin
        if (burn_q[k] < end_sat) burn_q[k] <= end_sat;
        if (beg_sat <= start_q[k]) start_q[k] <= beg_sat;
      end
    end
  end

  assign lit_d = is_tick ? lit_tick : lit_q;

  // Only the low lights show in the mask
  for (genvar i = 0; i < MASK_W; i++) begin : g_mask
    if (i < NUM_LIGHTS) begin : g_on
      assign mask_d[i] = lit_d[i];
    end else begin : g_off
      assign mask_d[i] = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      mask_q   <= mask_d;
      status_q <= (cmd_i.kind == CMD_BAD) ? STAT_BAD : STAT_OK;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign light_mask_o = mask_q;
  assign status_o     = status_q;

  // Checks
  a_now_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (now_q >= $past(now_q)))
    else $error("time counter went backwards");

  a_bad_keeps_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && (cmd_i.kind == CMD_BAD)) |=> $stable(now_q))
    else $error("invalid opcode changed time");

  a_bad_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && (cmd_i.kind == CMD_BAD)) |=> (out_valid_q && (status_q == STAT_BAD)))
    else $error("invalid opcode not reported");

  for (genvar k = 0; k < NUM_LIGHTS; k++) begin : g_chk
    a_lit_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
      lit_q[k] |-> ((start_q[k] <= now_q) && (now_q < burn_q[k])))
      else $error("light lit outside its window");
  end

endmodule

@@ rtl/staggered_light_sweep_timer.sv @@
// Staggered light sweep timer. Each accepted word (tick, sweep left, sweep
// right, all on, or an invalid opcode) yields exactly one result word with the
// lit mask of the first eight lights and a status bit. The block takes one
// word per clock while the queue is not full: a front stage decodes the opcode
// and computes every light's stagger delay with one constant multiply per
// light, a two-entry queue holds decoded words, and a bank of per-light compare
// cells applies one word per cycle into the output register unless the output
// stalls. The input stalls only when the queue is full. All timing state comes
// out of reset at once, with no clearing pass.
module staggered_light_sweep_timer import slst_pkg::*; #(
  parameter int NUM_LIGHTS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [DUR_W-1:0]  duration_ms_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [MASK_W-1:0] light_mask_o,
  output logic              status_o
);

  cmd_t             f_cmd;
  logic [DUR_W-1:0] f_delay [NUM_LIGHTS];
  cmd_t             q_cmd;
  logic [DUR_W-1:0] q_delay [NUM_LIGHTS];
  logic             q_valid;
  logic             q_full;
  logic             push;
  logic             pop;

  assign push       = in_valid_i && !q_full;
  assign in_stall_o = q_full;

  // Decode and stagger
  slst_front #(
    .NUM_LIGHTS(NUM_LIGHTS)
  ) u_front (
    .opcode_i      (opcode_i),
    .duration_ms_i (duration_ms_i),
    .cmd_o         (f_cmd),
    .delay_o       (f_delay)
  );

  // Decoupling queue
  slst_queue #(
    .NUM_LIGHTS(NUM_LIGHTS)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (f_cmd),
    .delay_i (f_delay),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .cmd_o   (q_cmd),
    .delay_o (q_delay)
  );

  // Light cells and result register
  slst_back #(
    .NUM_LIGHTS(NUM_LIGHTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (q_valid),
    .cmd_i        (q_cmd),
    .delay_i      (q_delay),
    .pop_o        (pop),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .light_mask_o (light_mask_o),
    .status_o     (status_o)
  );

endmodule
